FILE: hw/rtl/occupancy_grid_placer_defines.svh
// Assertion macros used by the occupancy grid placer controller.
`ifndef OCCUPANCY_GRID_PLACER_DEFINES_SVH
`define OCCUPANCY_GRID_PLACER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define OGP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("occupancy grid placer check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define OGP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("occupancy grid placer check failed");
`else
`define OGP_ASSERT_IMPL(lbl, ante, cons)
`define OGP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/ogp_pkg.sv
// Shared constants, types and helper functions of the occupancy grid placer.
`timescale 1ns / 1ps
package ogp_pkg;

    localparam int GRID_DIM  = 64;
    localparam int ROW_W     = $clog2(GRID_DIM);
    localparam int RAD_W     = ROW_W + 1;
    localparam int CELL_LOG2 = 3;
    localparam int CELL_SIZE = 1 << CELL_LOG2;
    localparam int PIX_W     = 11;
    localparam int COORD_W   = 13;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [GRID_DIM-1:0]       row_t;

    localparam coord_t GRID_C = coord_t'(GRID_DIM);
    localparam coord_t ZERO_C = coord_t'(0);
    localparam coord_t ONE_C  = coord_t'(1);

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_MARK   = 3'd1,
        CMD_UNMARK = 3'd2,
        CMD_TEST   = 3'd3,
        CMD_FIND   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_FAIL,
        RES_FOUND
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MARK_START,
        ST_MARK_WR,
        ST_SPAN_START,
        ST_SPAN_CHK,
        ST_RING_INIT,
        ST_SIDE_START,
        ST_CAND,
        ST_ITER_NEXT,
        ST_NEXT_SIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clear_grid;
        logic span_inplace;
        logic span_mark;
        logic rd_first;
        logic rd_next;
        logic write_row;
        logic ring_init;
        logic side_start;
        logic load_cand;
        logic iter_step;
        logic next_side;
        logic load_result;
        res_t res_sel;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic bounds_ok;
        logic rows_empty;
        logic row_hit;
        logic last_row;
        logic side_ok;
        logic iter_last;
        logic side_last;
        logic rad_last;
        logic out_busy;
    } sts_t;

    // Signed divide by the cell size, truncating toward zero.
    function automatic coord_t cell_div(input coord_t v);
        coord_t adj;
        adj = v[COORD_W-1] ? v + coord_t'(CELL_SIZE - 1) : v;
        return adj >>> CELL_LOG2;
    endfunction

    // Framed grid: border rows full, other rows only their first and last cells.
    function automatic row_t reset_row(input logic [ROW_W-1:0] r);
        row_t v;
        v = '0;
        v[0] = 1'b1;
        v[GRID_DIM-1] = 1'b1;
        if (r == '0 || r == ROW_W'(GRID_DIM - 1))
        begin
            v = '1;
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/ogp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ogp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ogp_datapath.sv
// Datapath: grid row memory, span checker, ring walker and result register.
`timescale 1ns / 1ps
module ogp_datapath
    import ogp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [2:0]              cmd,
    input  logic signed [PIX_W-1:0] rect_left,
    input  logic signed [PIX_W-1:0] rect_top,
    input  logic signed [PIX_W-1:0] rect_right,
    input  logic signed [PIX_W-1:0] rect_bottom,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    ok,
    output logic signed [PIX_W-1:0] pos_x,
    output logic signed [PIX_W-1:0] pos_y,
    input  ctl_t                    ctl,
    output sts_t                    sts
);

    cmd_t             cmd_reg;
    coord_t           x0_reg, y0_reg, x1_reg, y1_reg, w_reg, h_reg;
    logic [ROW_W-1:0] cx_reg, cy_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [1:0]       side_reg;
    coord_t           iter_reg;
    coord_t           sx0_reg, sy0_reg, sx1_reg, sy1_reg;
    logic [ROW_W-1:0] yptr_reg;
    row_t             valid_reg;
    logic             rd_valid_reg;
    logic [ROW_W-1:0] rd_addr_reg;
    logic             out_valid_reg, ok_reg;
    logic [PIX_W-1:0] pos_x_reg, pos_y_reg;

    coord_t l_c, t_c, r_c, b_c, x0_c, y0_c;
    coord_t rad_c, cxm, cxp, cym, cyp, ylo, yhi, xlo, xhi;
    coord_t fixed_c, start_c, end_c, tx_c, ty_c, shx, shy;
    logic   fixed_ok;
    logic [ROW_W-1:0] rd_addr;
    row_t   ram_q, row_q, mask, new_row;

    // Input decode: cell spans and size in cells
    assign l_c  = coord_t'(rect_left);
    assign t_c  = coord_t'(rect_top);
    assign r_c  = coord_t'(rect_right);
    assign b_c  = coord_t'(rect_bottom);
    assign x0_c = cell_div(l_c);
    assign y0_c = cell_div(t_c);

    // Ring geometry around the clamped anchor cell
    always_comb
    begin
        rad_c = coord_t'(rad_reg);
        cxm = coord_t'(cx_reg) - rad_c;
        cxp = coord_t'(cx_reg) + rad_c;
        cym = coord_t'(cy_reg) - rad_c;
        cyp = coord_t'(cy_reg) + rad_c;
        ylo = (cym < ZERO_C) ? ZERO_C : cym;
        yhi = (cyp + ONE_C > GRID_C) ? GRID_C : cyp + ONE_C;
        xlo = ((cxm < ZERO_C) ? ZERO_C : cxm) + ONE_C;
        xhi = ((cxp + ONE_C > GRID_C) ? GRID_C : cxp + ONE_C) - ONE_C;
        case (side_reg)
            2'd0:    begin fixed_c = cxm; fixed_ok = (cxm >= ZERO_C); end
            2'd1:    begin fixed_c = cxp; fixed_ok = (cxp < GRID_C);  end
            2'd2:    begin fixed_c = cym; fixed_ok = (cym >= ZERO_C); end
            default: begin fixed_c = cyp; fixed_ok = (cyp < GRID_C);  end
        endcase
        start_c = side_reg[1] ? xlo : ylo;
        end_c   = side_reg[1] ? xhi : yhi;
        tx_c    = side_reg[1] ? iter_reg : fixed_c;
        ty_c    = side_reg[1] ? fixed_c : iter_reg;
    end

    // Row memory; rows never written since clear read as the framed pattern
    assign rd_addr = ctl.rd_first ? sy0_reg[ROW_W-1:0] : yptr_reg + ROW_W'(1);

    ogp_ram #(
        .WIDTH (GRID_DIM),
        .DEPTH (GRID_DIM)
    ) u_rows (
        .clk   (clk),
        .we    (ctl.write_row),
        .waddr (yptr_reg),
        .wdata (new_row),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign row_q = rd_valid_reg ? ram_q : reset_row(rd_addr_reg);

    always_comb
    begin
        for (int i = 0; i < GRID_DIM; i++)
        begin
            mask[i] = (coord_t'(i) >= sx0_reg) && (coord_t'(i) <= sx1_reg);
        end
        new_row = (cmd_reg == CMD_MARK) ? (row_q | mask) : (row_q & ~mask);
    end

    assign shx = sx0_reg <<< CELL_LOG2;
    assign shy = sy0_reg <<< CELL_LOG2;

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[rd_addr];
        rd_addr_reg  <= rd_addr;
        if (ctl.load_in)
        begin
            cmd_reg <= cmd_t'(cmd);
            x0_reg  <= x0_c;
            y0_reg  <= y0_c;
            x1_reg  <= cell_div(r_c + coord_t'(CELL_SIZE - 1));
            y1_reg  <= cell_div(b_c + coord_t'(CELL_SIZE - 1));
            w_reg   <= cell_div(r_c - l_c + coord_t'(CELL_SIZE - 1));
            h_reg   <= cell_div(b_c - t_c + coord_t'(CELL_SIZE - 1));
            cx_reg  <= (x0_c < ZERO_C) ? '0 :
                       (x0_c >= GRID_C) ? ROW_W'(GRID_DIM - 1) : x0_c[ROW_W-1:0];
            cy_reg  <= (y0_c < ZERO_C) ? '0 :
                       (y0_c >= GRID_C) ? ROW_W'(GRID_DIM - 1) : y0_c[ROW_W-1:0];
        end
        if (ctl.span_inplace)
        begin
            sx0_reg <= x0_reg;
            sy0_reg <= y0_reg;
            sx1_reg <= x1_reg;
            sy1_reg <= y1_reg;
        end
        else if (ctl.span_mark)
        begin
            sx0_reg <= x0_reg;
            sx1_reg <= x1_reg;
            sy0_reg <= (y0_reg < ZERO_C) ? ZERO_C : y0_reg;
            sy1_reg <= (y1_reg >= GRID_C) ? GRID_C - ONE_C : y1_reg;
        end
        else if (ctl.load_cand)
        begin
            sx0_reg <= tx_c;
            sy0_reg <= ty_c;
            sx1_reg <= tx_c + w_reg;
            sy1_reg <= ty_c + h_reg;
        end
        if (ctl.rd_first)
        begin
            yptr_reg <= sy0_reg[ROW_W-1:0];
        end
        else if (ctl.rd_next)
        begin
            yptr_reg <= yptr_reg + ROW_W'(1);
        end
        if (ctl.side_start)
        begin
            iter_reg <= start_c;
        end
        else if (ctl.iter_step)
        begin
            iter_reg <= iter_reg + ONE_C;
        end
        if (ctl.load_result)
        begin
            case (ctl.res_sel)
                RES_OK:
                begin
                    ok_reg    <= 1'b1;
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                end
                RES_FOUND:
                begin
                    ok_reg    <= 1'b1;
                    pos_x_reg <= shx[PIX_W-1:0];
                    pos_y_reg <= shy[PIX_W-1:0];
                end
                default:
                begin
                    ok_reg    <= 1'b0;
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rad_reg       <= '0;
            side_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear_grid)
            begin
                valid_reg <= '0;
            end
            else if (ctl.write_row)
            begin
                valid_reg[yptr_reg] <= 1'b1;
            end
            if (ctl.ring_init)
            begin
                rad_reg  <= RAD_W'(1);
                side_reg <= '0;
            end
            else if (ctl.next_side)
            begin
                side_reg <= side_reg + 2'd1;
                if (side_reg == 2'd3)
                begin
                    rad_reg <= rad_reg + RAD_W'(1);
                end
            end
            if (ctl.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.bounds_ok  = (sx0_reg >= ZERO_C) && (sy0_reg >= ZERO_C) &&
                         (sx1_reg < GRID_C) && (sy1_reg < GRID_C);
        sts.rows_empty = (sy1_reg < sy0_reg);
        sts.row_hit    = |(row_q & mask);
        sts.last_row   = (yptr_reg == sy1_reg[ROW_W-1:0]);
        sts.side_ok    = fixed_ok && (start_c < end_c);
        sts.iter_last  = (iter_reg + ONE_C >= end_c);
        sts.side_last  = (side_reg == 2'd3);
        sts.rad_last   = (rad_reg == RAD_W'(GRID_DIM - 1));
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

endmodule

FILE: hw/rtl/ogp_ctrl.sv
// Controller state machine sequencing commands, span checks and the ring search.
`timescale 1ns / 1ps
`include "occupancy_grid_placer_defines.svh"
module ogp_ctrl
    import ogp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output ctl_t ctl,
    input  sts_t sts
);

    state_t state_reg, state_next;
    res_t   res_reg, res_next;
    logic   ring_reg, ring_next;
    logic   mark_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= RES_FAIL;
            ring_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            ring_reg  <= ring_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        ring_next   = ring_reg;
        ctl         = '0;
        ctl.res_sel = res_reg;
        in_ready    = 1'b0;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    ring_next   = 1'b0;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.cmd) inside
                    CMD_CLEAR:
                    begin
                        ctl.clear_grid = 1'b1;
                        res_next       = RES_OK;
                        state_next     = ST_DONE;
                    end
                    CMD_MARK, CMD_UNMARK:
                    begin
                        ctl.span_mark = 1'b1;
                        state_next    = ST_MARK_START;
                    end
                    CMD_TEST, CMD_FIND:
                    begin
                        ctl.span_inplace = 1'b1;
                        state_next       = ST_SPAN_START;
                    end
                    default:
                    begin
                        res_next   = RES_FAIL;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MARK_START:
            begin
                if (sts.rows_empty)
                begin
                    res_next   = RES_OK;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.rd_first = 1'b1;
                    state_next   = ST_MARK_WR;
                end
            end
            ST_MARK_WR:
            begin
                // write this row back while the next one is read
                ctl.write_row = 1'b1;
                if (sts.last_row)
                begin
                    res_next   = RES_OK;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.rd_next = 1'b1;
                end
            end
            ST_SPAN_START, ST_SPAN_CHK:
            begin
                if ((state_reg == ST_SPAN_START && !sts.bounds_ok) ||
                    (state_reg == ST_SPAN_CHK && sts.row_hit))
                begin
                    if (sts.cmd == CMD_TEST)
                    begin
                        res_next   = RES_FAIL;
                        state_next = ST_DONE;
                    end
                    else if (!ring_reg)
                    begin
                        ring_next  = 1'b1;
                        state_next = ST_RING_INIT;
                    end
                    else
                    begin
                        state_next = ST_ITER_NEXT;
                    end
                end
                else if ((state_reg == ST_SPAN_START && sts.rows_empty) ||
                         (state_reg == ST_SPAN_CHK && sts.last_row))
                begin
                    res_next   = (sts.cmd == CMD_FIND) ? RES_FOUND : RES_OK;
                    state_next = ST_DONE;
                end
                else if (state_reg == ST_SPAN_START)
                begin
                    ctl.rd_first = 1'b1;
                    state_next   = ST_SPAN_CHK;
                end
                else
                begin
                    ctl.rd_next = 1'b1;
                end
            end
            ST_RING_INIT:
            begin
                ctl.ring_init = 1'b1;
                state_next    = ST_SIDE_START;
            end
            ST_SIDE_START:
            begin
                if (sts.side_ok)
                begin
                    ctl.side_start = 1'b1;
                    state_next     = ST_CAND;
                end
                else
                begin
                    state_next = ST_NEXT_SIDE;
                end
            end
            ST_CAND:
            begin
                ctl.load_cand = 1'b1;
                state_next    = ST_SPAN_START;
            end
            ST_ITER_NEXT:
            begin
                if (sts.iter_last)
                begin
                    state_next = ST_NEXT_SIDE;
                end
                else
                begin
                    ctl.iter_step = 1'b1;
                    state_next    = ST_CAND;
                end
            end
            ST_NEXT_SIDE:
            begin
                if (sts.side_last && sts.rad_last)
                begin
                    res_next   = RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.next_side = 1'b1;
                    state_next    = ST_SIDE_START;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    ctl.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mark_state = (state_reg == ST_MARK_START) || (state_reg == ST_MARK_WR);

    `OGP_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_reg == ST_DISPATCH)
    `OGP_ASSERT_IMPL(a_no_overwrite, ctl.load_result, !sts.out_busy)
    `OGP_ASSERT_IMPL(a_write_after_read, state_reg == ST_MARK_WR, $past(mark_state))

endmodule

FILE: hw/rtl/occupancy_grid_placer.sv
// Top level of the occupancy grid placer: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_ready   | cmd, rect_left/top/right/bottom
//  out     | output    | out_valid / out_ready | ok, pos_x, pos_y
//
// One command is worked on at a time; in_ready is high only while idle.
// Mark and unmark rewrite each row touched; test checks the rows one by one and
// stops on the first busy row. A search repeats that row check for each ring
// candidate; the row memory's single read port (one 64-bit row per cycle) sets
// that pace, so a search that fails over a full grid checks every ring candidate.
// Reset (rst_n, async) restores the framed grid at once through per-row valid
// bits; a finished result waits in the output register while out_ready is low.
`timescale 1ns / 1ps
module occupancy_grid_placer
    import ogp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              cmd,
    input  logic signed [PIX_W-1:0] rect_left,
    input  logic signed [PIX_W-1:0] rect_top,
    input  logic signed [PIX_W-1:0] rect_right,
    input  logic signed [PIX_W-1:0] rect_bottom,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    ok,
    output logic signed [PIX_W-1:0] pos_x,
    output logic signed [PIX_W-1:0] pos_y
);

    // command and status between the two halves
    ctl_t ctl;
    sts_t sts;

    ogp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // grid rows, span checker, ring walker and the output transaction register
    ogp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule
